@@ hdl/pidsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidsp_pkg
// Types, constants and helpers for the PID speed to pedal frame block.
// ----------------------------------------------------------------------------
package pidsp_pkg;

  localparam int CFG_W   = 25;          // widest register
  localparam int IDX_W   = 3;
  localparam int ACC_W   = 60;          // product accumulator
  localparam int SAT_W   = ACC_W - 16;  // accumulator after the Q16.16 shift
  localparam int ERR_W   = 24;
  localparam int MULT_W  = 25;
  localparam int FRAME_N = 17;
  localparam int CNT_W   = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_N - 1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ACC_SC   = 3'd5;
  localparam logic [IDX_W-1:0] REG_BRK_SC   = 3'd6;
  localparam logic [IDX_W-1:0] REG_ACC_OFS  = 3'd7;

  localparam logic [7:0] CMD_MIN      = 8'd100;
  localparam logic [7:0] CMD_MAX      = 8'd200;
  localparam logic [7:0] STEER_CENTER = 8'd140;
  localparam logic signed [7:0] STEER_LIM = 8'sd40;
  localparam logic [7:0] ASCII_ZERO   = 8'd48;
  localparam logic [7:0] GEAR_CODE    = 8'd2;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;

  // floor(x * 5 / 18) = (x * 18205) >> 16 for x below 256
  localparam logic [14:0] KMH_RECIP   = 15'd18205;

  localparam logic signed [ACC_W-1:0] PA_LIMIT = -(60'sd2 <<< 40);

  typedef struct packed {
    logic        [7:0] speed_kmh;
    logic signed [7:0] steer_target;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ERR  = 13'b0000000000010,
    S_MST  = 13'b0000000000100,
    S_INT  = 13'b0000000001000,
    S_MGP  = 13'b0000000010000,
    S_MGI  = 13'b0000000100000,
    S_MGD  = 13'b0000001000000,
    S_DRV  = 13'b0000010000000,
    S_MPA  = 13'b0000100000000,
    S_PA   = 13'b0001000000000,
    S_MPB  = 13'b0010000000000,
    S_CMD  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic fits;
    fits = (x[SAT_W-1:31] == '0) || (x[SAT_W-1:31] == '1);
    if (fits) return x[31:0];
    return x[SAT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Q20.40 to command: truncate, clamp to 100..200
  function automatic logic [7:0] cmd_from(input logic signed [ACC_W-1:0] q);
    logic [ACC_W-41:0] v;
    v = q[ACC_W-1:40];
    if (q[ACC_W-1])            return CMD_MIN;
    if (v > 20'(CMD_MAX))      return CMD_MAX;
    if (v < 20'(CMD_MIN))      return CMD_MIN;
    return v[7:0];
  endfunction

  // three ASCII digits of a value in 100..200, hundreds first
  function automatic logic [23:0] ascii3(input logic [7:0] v);
    logic [7:0]  h;
    logic [7:0]  r;
    logic [14:0] pr;
    logic [7:0]  t;
    logic [7:0]  u;
    h  = (v >= 8'd200) ? 8'd2 : 8'd1;
    r  = (v >= 8'd200) ? (v - 8'd200) : (v - 8'd100);
    pr = 15'(r[6:0]) * 15'd205;      // r / 10 for r below 100
    t  = 8'(pr[14:11]);
    u  = r - 8'(t * 8'd10);
    return {ASCII_ZERO + h, ASCII_ZERO + t, ASCII_ZERO + u};
  endfunction

endpackage
`default_nettype wire

@@ hdl/pid_speed_to_pedal_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_speed_to_pedal_frame
// PID speed loop that turns one speed/steering sample into a 17-byte frame.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready/in_data carries one sample per control
//   tick: measured speed in km/h and a signed steering target in degrees.
//   Output channel out_valid/out_ready/out_data returns the command frame,
//   one ASCII byte per transfer, frame_last set on byte 16.
//   cfg_we/cfg_index/cfg_wdata write the eight loop registers; write them
//   only while no sample is in flight.
// Timing
//   All products go through one shift-add multiplier, one multiplier bit per
//   cycle; a pass stops once the remaining gain bits are zero. Six passes
//   (step time, three gains, two pedal scales) and five other steps lie
//   between the input transfer and the first frame byte on out_data. One
//   sample at a time: in_ready is high only once the last byte has gone.
// Reset
//   Registers return to their defaults, integral and previous error clear.
// Stall
//   The frame sits in a byte shift register; out_data holds while out_ready
//   is low and nothing is lost.
// ----------------------------------------------------------------------------
module pid_speed_to_pedal_frame (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  pidsp_pkg::in_t               in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output pidsp_pkg::out_t              out_data,
  input  wire                          cfg_we,
  input  wire  [pidsp_pkg::IDX_W-1:0]  cfg_index,
  input  wire  [pidsp_pkg::CFG_W-1:0]  cfg_wdata
);
  import pidsp_pkg::*;

  // loop registers
  logic [21:0] target_r;
  logic [22:0] gain_p_r, gain_i_r, gain_d_r;
  logic [16:0] step_r;
  logic [24:0] acc_sc_r, brk_sc_r;
  logic [6:0]  acc_ofs_r;

  state_t state_r, state_nxt;

  logic        [6:0]       speed_r,    speed_nxt;
  logic signed [7:0]       steer_r,    steer_nxt;
  logic signed [ERR_W-1:0] err_r,      err_nxt;
  logic signed [32:0]      diff_r,     diff_nxt;
  logic signed [31:0]      integ_r,    integ_nxt;
  logic signed [31:0]      prev_r,     prev_nxt;
  logic signed [31:0]      drive_r,    drive_nxt;
  logic signed [ACC_W-1:0] acc_r,      acc_nxt;
  logic signed [ACC_W-1:0] mcand_r,    mcand_nxt;
  logic        [MULT_W-1:0] mult_r,    mult_nxt;
  logic signed [ACC_W-1:0] qa_r,       qa_nxt;
  logic                    pa_ok_r,    pa_ok_nxt;
  logic        [7:0]       frame_r [FRAME_N];
  logic        [7:0]       frame_nxt [FRAME_N];
  logic        [CNT_W-1:0] cnt_r,      cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic        [22:0]       kmh_prod;
  logic signed [ERR_W-1:0]  err_c;
  logic                     mul_done;
  logic signed [SAT_W-1:0]  integ_sum;
  logic signed [ACC_W-1:0]  qb_c;
  logic        [7:0]        acc_cmd, brk_cmd, str_cmd;
  logic signed [7:0]        steer_cl;
  logic        [23:0]       str_d, brk_d, acc_d;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= 22'd131072;
      gain_p_r  <= 23'd524288;
      gain_i_r  <= 23'd983040;
      gain_d_r  <= 23'd245760;
      step_r    <= 17'd5243;
      acc_sc_r  <= 25'd16777;
      brk_sc_r  <= 25'd134218;
      acc_ofs_r <= 7'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:  target_r  <= cfg_wdata[21:0];
        REG_GAIN_P:  gain_p_r  <= cfg_wdata[22:0];
        REG_GAIN_I:  gain_i_r  <= cfg_wdata[22:0];
        REG_GAIN_D:  gain_d_r  <= cfg_wdata[22:0];
        REG_STEP:    step_r    <= cfg_wdata[16:0];
        REG_ACC_SC:  acc_sc_r  <= cfg_wdata[24:0];
        REG_BRK_SC:  brk_sc_r  <= cfg_wdata[24:0];
        REG_ACC_OFS: acc_ofs_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // ---- datapath helpers ---------------------------------------------------
  assign kmh_prod  = 23'(in_data.speed_kmh) * 23'(KMH_RECIP);
  // error = target - speed_ms in Q16.16
  assign err_c     = $signed({2'b00, target_r}) - $signed({1'b0, speed_r, 16'd0});
  assign mul_done  = (mult_r == '0);
  // previous integral plus floor(err * step_time / 2^16)
  assign integ_sum = $signed({{(SAT_W-32){integ_r[31]}}, integ_r}) + acc_r[ACC_W-1:16];
  assign qb_c      = $signed({12'd0, CMD_MIN, 40'd0}) - acc_r;

  assign steer_cl  = (steer_r > STEER_LIM)  ? STEER_LIM :
                     (steer_r < -STEER_LIM) ? -STEER_LIM : steer_r;
  assign str_cmd   = STEER_CENTER + 8'(steer_cl);
  // throttle when the drive is not clearly negative, brake otherwise
  assign acc_cmd   = pa_ok_r ? cmd_from(qa_r) : CMD_MIN;
  assign brk_cmd   = pa_ok_r ? CMD_MIN : cmd_from(qb_c);
  assign str_d     = ascii3(str_cmd);
  assign brk_d     = ascii3(brk_cmd);
  assign acc_d     = ascii3(acc_cmd);

  // ---- sequencer ----------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    steer_nxt     = steer_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    integ_nxt     = integ_r;
    prev_nxt      = prev_r;
    drive_nxt     = drive_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mult_nxt      = mult_r;
    qa_nxt        = qa_r;
    pa_ok_nxt     = pa_ok_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < FRAME_N; i++) frame_nxt[i] = frame_r[i];

    // one multiplier bit per cycle in the product states
    if (!mul_done) begin
      if (mult_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r <<< 1;
      mult_nxt  = mult_r >> 1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          speed_nxt = kmh_prod[22:16];
          steer_nxt = in_data.steer_target;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt   = err_c;
        acc_nxt   = '0;
        mcand_nxt = {{(ACC_W-ERR_W){err_c[ERR_W-1]}}, err_c};
        mult_nxt  = MULT_W'(step_r);
        state_nxt = S_MST;
      end
      S_MST: begin
        if (mul_done) state_nxt = S_INT;
      end
      S_INT: begin
        integ_nxt = sat32(integ_sum);
        diff_nxt  = 33'(err_r) - 33'(prev_r);
        prev_nxt  = 32'(err_r);
        acc_nxt   = '0;
        mcand_nxt = {{(ACC_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mult_nxt  = MULT_W'(gain_p_r);
        state_nxt = S_MGP;
      end
      S_MGP: begin
        if (mul_done) begin
          mcand_nxt = {{(ACC_W-32){integ_r[31]}}, integ_r};
          mult_nxt  = MULT_W'(gain_i_r);
          state_nxt = S_MGI;
        end
      end
      S_MGI: begin
        if (mul_done) begin
          mcand_nxt = {{(ACC_W-33){diff_r[32]}}, diff_r};
          mult_nxt  = MULT_W'(gain_d_r);
          state_nxt = S_MGD;
        end
      end
      S_MGD: begin
        if (mul_done) state_nxt = S_DRV;
      end
      S_DRV: begin
        drive_nxt = sat32(acc_r[ACC_W-1:16]);
        acc_nxt   = '0;
        mcand_nxt = {{(ACC_W-32){drive_nxt[31]}}, drive_nxt};
        mult_nxt  = acc_sc_r;
        state_nxt = S_MPA;
      end
      S_MPA: begin
        if (mul_done) state_nxt = S_PA;
      end
      S_PA: begin
        pa_ok_nxt = (acc_r >= PA_LIMIT);
        qa_nxt    = $signed({12'd0, CMD_MIN + {1'b0, acc_ofs_r}, 40'd0}) + acc_r;
        acc_nxt   = '0;
        mcand_nxt = {{(ACC_W-32){drive_r[31]}}, drive_r};
        mult_nxt  = brk_sc_r;
        state_nxt = S_MPB;
      end
      S_MPB: begin
        if (mul_done) state_nxt = S_CMD;
      end
      S_CMD: begin
        frame_nxt[0]  = CH_SLASH;
        frame_nxt[1]  = ASCII_ZERO + GEAR_CODE;
        frame_nxt[2]  = ASCII_ZERO;
        frame_nxt[3]  = ASCII_ZERO;
        frame_nxt[4]  = str_d[23:16];
        frame_nxt[5]  = str_d[15:8];
        frame_nxt[6]  = str_d[7:0];
        frame_nxt[7]  = brk_d[23:16];
        frame_nxt[8]  = brk_d[15:8];
        frame_nxt[9]  = brk_d[7:0];
        frame_nxt[10] = acc_d[23:16];
        frame_nxt[11] = acc_d[15:8];
        frame_nxt[12] = acc_d[7:0];
        frame_nxt[13] = ASCII_ZERO;
        frame_nxt[14] = ASCII_ZERO;
        frame_nxt[15] = CH_BSLASH;
        frame_nxt[16] = CH_N;
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (cnt_r == CNT_LAST) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            for (int i = 0; i < FRAME_N - 1; i++) frame_nxt[i] = frame_r[i+1];
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
      mult_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      mult_r      <= mult_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    steer_r <= steer_nxt;
    err_r   <= err_nxt;
    diff_r  <= diff_nxt;
    drive_r <= drive_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    qa_r    <= qa_nxt;
    pa_ok_r <= pa_ok_nxt;
    cnt_r   <= cnt_nxt;
    for (int i = 0; i < FRAME_N; i++) frame_r[i] <= frame_nxt[i];
  end

  // ---- ports --------------------------------------------------------------
  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_data.frame_byte = frame_r[0];
  assign out_data.frame_last = (cnt_r == CNT_LAST);

  // ---- checks -------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a frame is pending");

  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUT))
    else $error("frame byte shown outside the output state");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r == '0) |-> (out_data.frame_byte == CH_SLASH))
    else $error("frame does not open with a slash");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.frame_last) |=> (!out_valid && in_ready))
    else $error("block not idle after the last byte");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ERR))
    else $error("input transfer did not start the loop");

endmodule
`default_nettype wire
